// ----- hw/rtl/alignment_end_trimmer_unit_assert.svh -----
// Assertion macros for the trimmer RTL (included by aet_core).
`ifndef ALIGNMENT_END_TRIMMER_UNIT_ASSERT_SVH
`define ALIGNMENT_END_TRIMMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/aet_pkg.sv -----
`default_nettype none

package aet_pkg;

    localparam int CHAR_W          = 8;
    localparam int COORD_W         = 32;
    localparam int COLOUT_W        = 17;
    localparam int RUN_W           = 4;
    localparam int RUN_LENGTH_DEF  = 8;
    localparam int MAX_COLUMNS_DEF = 65536;

    localparam logic [CHAR_W-1:0] GAP_CODE = 8'd45;

    typedef struct packed {
        logic [CHAR_W-1:0]  query_char;
        logic [CHAR_W-1:0]  subject_char;
        logic               last_column;
        logic [COORD_W-1:0] query_start;
        logic [COORD_W-1:0] query_stop;
        logic [COORD_W-1:0] subject_start;
        logic [COORD_W-1:0] subject_stop;
    } t_item;

    typedef struct packed {
        logic                success;
        logic [COLOUT_W-1:0] first_column;
        logic [COLOUT_W-1:0] end_column;
        logic [COORD_W-1:0]  new_query_start;
        logic [COORD_W-1:0]  new_query_stop;
        logic [COORD_W-1:0]  new_subject_start;
        logic [COORD_W-1:0]  new_subject_stop;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/aet_in_reg.sv -----
`default_nettype none

module aet_in_reg
    import aet_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  w_load;

    assign o_stall = r_vld && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        if (w_load) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- hw/rtl/aet_core.sv -----
`default_nettype none

module aet_core
    import aet_pkg::*;
#(
    parameter int RUN_LENGTH  = RUN_LENGTH_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int DLY   = (RUN_LENGTH > 1) ? RUN_LENGTH - 1 : 1;

    typedef logic [COL_W-1:0] t_col;
    typedef struct packed {
        t_col q;
        t_col s;
    } t_pref;

    localparam t_col             COL_MAX = COL_W'(MAX_COLUMNS);
    localparam t_col             RL_COL  = COL_W'(RUN_LENGTH);
    localparam logic [RUN_W-1:0] RL_RUN  = RUN_W'(RUN_LENGTH);

    logic [RUN_W-1:0] r_run, n_run;
    t_col             r_col, n_col;
    t_col             r_qtot, n_qtot;
    t_col             r_stot, n_stot;
    logic             r_fw_found, n_fw_found;
    t_col             r_fw_end, n_fw_end;
    t_col             r_fw_q, n_fw_q;
    t_col             r_fw_s, n_fw_s;
    t_col             r_lw_start, n_lw_start;
    t_col             r_lw_q, n_lw_q;
    t_col             r_lw_s, n_lw_s;
    t_pref            r_dly [DLY];

    logic             w_tl;
    t_pref            w_tap;
    logic             w_ok;
    logic [COORD_W-1:0] w_first;
    logic [COORD_W-1:0] w_end;
    logic [COORD_W-1:0] w_back_q;
    logic [COORD_W-1:0] w_back_s;

    assign w_tl = (r_col >= COL_MAX);

    // prefix counts of the column where the run started (RUN_LENGTH-1 back)
    assign w_tap = (RUN_LENGTH == 1) ? t_pref'{q: r_qtot, s: r_stot} : r_dly[DLY-1];

    always_comb begin
        n_run      = r_run;
        n_col      = r_col;
        n_qtot     = r_qtot;
        n_stot     = r_stot;
        n_fw_found = r_fw_found;
        n_fw_end   = r_fw_end;
        n_fw_q     = r_fw_q;
        n_fw_s     = r_fw_s;
        n_lw_start = r_lw_start;
        n_lw_q     = r_lw_q;
        n_lw_s     = r_lw_s;
        if (!w_tl) begin
            n_qtot = r_qtot + COL_W'(i_item.query_char != GAP_CODE);
            n_stot = r_stot + COL_W'(i_item.subject_char != GAP_CODE);
            if (i_item.query_char == i_item.subject_char) begin
                if (r_run < RL_RUN) begin
                    n_run = r_run + RUN_W'(1);
                end
            end else begin
                n_run = '0;
            end
            if (n_run == RL_RUN) begin
                if (!r_fw_found) begin
                    n_fw_found = 1'b1;
                    n_fw_end   = r_col;
                    n_fw_q     = n_qtot;
                    n_fw_s     = n_stot;
                end
                n_lw_start = r_col + COL_W'(1) - RL_COL;
                n_lw_q     = w_tap.q;
                n_lw_s     = w_tap.s;
            end
            n_col = r_col + COL_W'(1);
        end
    end

    assign w_ok = !w_tl && n_fw_found && ((n_fw_end + COL_W'(1)) != n_col)
                  && (n_lw_start != '0);

    assign w_first  = COORD_W'(n_fw_end) + COORD_W'(1) - COORD_W'(RUN_LENGTH);
    assign w_end    = COORD_W'(n_lw_start) + COORD_W'(RUN_LENGTH);
    assign w_back_q = COORD_W'(n_qtot - n_lw_q);
    assign w_back_s = COORD_W'(n_stot - n_lw_s);

    always_comb begin
        o_result = '0;
        if (w_ok) begin
            o_result.success           = 1'b1;
            o_result.first_column      = w_first[COLOUT_W-1:0];
            o_result.end_column        = w_end[COLOUT_W-1:0];
            o_result.new_query_start   = i_item.query_start + COORD_W'(n_fw_q)
                                         - COORD_W'(RUN_LENGTH);
            o_result.new_query_stop    = i_item.query_stop - w_back_q
                                         + COORD_W'(RUN_LENGTH);
            o_result.new_subject_start = i_item.subject_start + COORD_W'(n_fw_s)
                                         - COORD_W'(RUN_LENGTH);
            o_result.new_subject_stop  = i_item.subject_stop - w_back_s
                                         + COORD_W'(RUN_LENGTH);
        end
    end

    // the last column of an alignment returns the tracker to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_item.last_column)) begin
            r_run      <= '0;
            r_col      <= '0;
            r_qtot     <= '0;
            r_stot     <= '0;
            r_fw_found <= 1'b0;
            r_fw_end   <= '0;
            r_fw_q     <= '0;
            r_fw_s     <= '0;
            r_lw_start <= '0;
            r_lw_q     <= '0;
            r_lw_s     <= '0;
        end else if (i_go) begin
            r_run      <= n_run;
            r_col      <= n_col;
            r_qtot     <= n_qtot;
            r_stot     <= n_stot;
            r_fw_found <= n_fw_found;
            r_fw_end   <= n_fw_end;
            r_fw_q     <= n_fw_q;
            r_fw_s     <= n_fw_s;
            r_lw_start <= n_lw_start;
            r_lw_q     <= n_lw_q;
            r_lw_s     <= n_lw_s;
        end
    end

    // delay line of prefix counts: r_dly[k] holds column (index - 1 - k)
    always_ff @(posedge i_clk) begin
        if (i_go && !w_tl) begin
            r_dly[0] <= '{q: r_qtot, s: r_stot};
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

`include "alignment_end_trimmer_unit_assert.svh"

    `AET_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, i_go && i_item.last_column, (r_col == '0) && (r_run == '0) && !r_fw_found, "state not cleared after last column")
    `AET_ASSERT_IMP(a_fw_before_col, i_clk, i_rst_n, r_fw_found, r_fw_end < r_col, "first window end not below column index")
    `AET_ASSERT_IMP(a_run_implies_fw, i_clk, i_rst_n, r_run == RL_RUN, r_fw_found, "full run without a first window")
    `AET_ASSERT_NXT(a_col_step, i_clk, i_rst_n, i_go && !i_item.last_column && !w_tl, r_col == $past(r_col) + COL_W'(1), "column index did not advance")

endmodule

`default_nettype wire

// ----- hw/rtl/aet_out_reg.sv -----
`default_nettype none

module aet_out_reg
    import aet_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_vld;
    logic    n_vld;
    t_result r_result;

    assign o_free = !r_vld || !i_stall;

    always_comb begin
        if (i_load) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/alignment_end_trimmer_unit.sv -----
// Alignment end trimmer.
// Input channel: one alignment column per transaction (query and subject
// characters, last-column flag, and the four coordinates, which matter only
// on the last column). Accepted when i_in_valid is high and o_in_stall low.
// Output channel: one result transaction per alignment, issued for the last
// column only; taken when o_out_valid is high and i_out_stall low.
// A last column enters an input register, passes through the run tracker
// and lands in the result register, where its result is held until it is
// taken.
// Throughput: one column per cycle. Ordinary columns keep flowing while a
// result is stalled; a last column waits in the input register until the
// result register frees, and holds further columns back meanwhile.
// Reset (synchronous, active low) empties both registers and clears the run
// counter, column index, non-gap counts and window records. The tracker
// state is cleared again after each last column, for the next alignment.
// No clearing pass is needed; the block accepts columns right after reset.
`default_nettype none

module alignment_end_trimmer_unit
    import aet_pkg::*;
#(
    parameter int RUN_LENGTH  = RUN_LENGTH_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CHAR_W-1:0]   i_query_char,
    input  wire logic [CHAR_W-1:0]   i_subject_char,
    input  wire logic                i_last_column,
    input  wire logic [COORD_W-1:0]  i_query_start,
    input  wire logic [COORD_W-1:0]  i_query_stop,
    input  wire logic [COORD_W-1:0]  i_subject_start,
    input  wire logic [COORD_W-1:0]  i_subject_stop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_success,
    output logic [COLOUT_W-1:0]      o_first_column,
    output logic [COLOUT_W-1:0]      o_end_column,
    output logic [COORD_W-1:0]       o_new_query_start,
    output logic [COORD_W-1:0]       o_new_query_stop,
    output logic [COORD_W-1:0]       o_new_subject_start,
    output logic [COORD_W-1:0]       o_new_subject_stop
);

    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_vld;
    logic    w_go;
    logic    w_out_free;
    t_result w_core_result;
    t_result w_out_result;

    assign w_in_item = '{
        query_char:    i_query_char,
        subject_char:  i_subject_char,
        last_column:   i_last_column,
        query_start:   i_query_start,
        query_stop:    i_query_stop,
        subject_start: i_subject_start,
        subject_stop:  i_subject_stop
    };

    // a last column needs room in the result register, other columns do not
    assign w_go = w_s1_vld && (!w_s1_item.last_column || w_out_free);

    aet_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_go),
        .o_stall   (o_in_stall),
        .o_valid   (w_s1_vld),
        .o_item    (w_s1_item)
    );

    aet_core #(
        .RUN_LENGTH  (RUN_LENGTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (w_s1_item),
        .o_result (w_core_result)
    );

    aet_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_go && w_s1_item.last_column),
        .i_result (w_core_result),
        .i_stall  (i_out_stall),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_success           = w_out_result.success;
    assign o_first_column      = w_out_result.first_column;
    assign o_end_column        = w_out_result.end_column;
    assign o_new_query_start   = w_out_result.new_query_start;
    assign o_new_query_stop    = w_out_result.new_query_stop;
    assign o_new_subject_start = w_out_result.new_subject_start;
    assign o_new_subject_stop  = w_out_result.new_subject_stop;

endmodule

`default_nettype wire
